[design/pwm_pkg.sv]
// Shared widths, register indexes, threshold bundle and constant tables for the watermark monitor.
package pwm_pkg;

    // Field widths
    localparam int LEVEL_W = 20;
    localparam int TOTAL_W = 44;
    localparam int THR_W   = 40;   // a level in MB shifted up by 20 bits
    localparam int MB_SHIFT = 20;

    // APB register map
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_CAP  = 2'd0;
    localparam logic [1:0] REG_WARN = 2'd1;
    localparam logic [1:0] REG_CRIT = 2'd2;

    // Reciprocal of 5 for 20-bit operands: q = (x * RECIP5) >> RECIP5_SHIFT
    localparam int Q5_W = 18;
    localparam int RECIP5_SHIFT = 22;
    localparam logic [LEVEL_W-1:0] RECIP5 = 20'd838861;

    // Cycles the threshold pipeline needs after a register write
    localparam logic [1:0] CFG_SETTLE = 2'd3;

    // Thresholds and re-arm levels handed from the config block to the datapath
    typedef struct packed {
        logic             enable;
        logic [THR_W-1:0] warn_thr;
        logic [THR_W-1:0] warn_rearm;
        logic [THR_W-1:0] crit_thr;
        logic [THR_W-1:0] crit_rearm;
    } t_thr;

    // floor(r * 2^19 / 5) for a remainder r of a division by 5
    function automatic logic [18:0] rem5_frac(input logic [2:0] r);
        logic [18:0] v;
        case (r)
            3'd0:    v = 19'd0;
            3'd1:    v = 19'd104857;
            3'd2:    v = 19'd209715;
            3'd3:    v = 19'd314572;
            3'd4:    v = 19'd419430;
            default: v = 19'd0;
        endcase
        return v;
    endfunction

endpackage

[design/pwm_cfg.sv]
// APB register file and the short pipeline that turns MB levels into byte thresholds.
module pwm_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pwm_pkg::ADDR_W-1:0]  paddr,
    input  logic [pwm_pkg::DATA_W-1:0]  pwdata,
    output logic [pwm_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic                        o_settled,
    output pwm_pkg::t_thr               o_thr
);

    logic [pwm_pkg::LEVEL_W-1:0] r_cap_mb, r_warn_mb, r_crit_mb;
    logic [1:0]                  r_settle;
    logic [pwm_pkg::Q5_W-1:0]    r_q5;
    logic [pwm_pkg::THR_W-1:0]   r_warn_thr, r_crit_thr;
    logic [pwm_pkg::THR_W-1:0]   r_warn_rearm, r_crit_rearm;

    logic                        wr_en;
    logic [1:0]                  reg_idx;
    logic [2*pwm_pkg::LEVEL_W-1:0] q5_prod;
    logic [pwm_pkg::LEVEL_W-1:0] rem_full;
    logic [2:0]                  rem5;
    logic [36:0]                 div10;
    logic [pwm_pkg::THR_W-1:0]   cap_bytes, crit_dflt, warn_dflt;
    logic [pwm_pkg::THR_W-1:0]   warn_raw, crit_raw, n_warn_thr, n_crit_thr;
    logic [21:0]                 cap_x3;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Register writes; start the settle count on any write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_mb  <= '0;
            r_warn_mb <= '0;
            r_crit_mb <= '0;
            r_settle  <= '0;
        end else begin
            if (wr_en) begin
                r_settle <= pwm_pkg::CFG_SETTLE;
                case (reg_idx)
                    pwm_pkg::REG_CAP:  r_cap_mb  <= pwdata[pwm_pkg::LEVEL_W-1:0];
                    pwm_pkg::REG_WARN: r_warn_mb <= pwdata[pwm_pkg::LEVEL_W-1:0];
                    pwm_pkg::REG_CRIT: r_crit_mb <= pwdata[pwm_pkg::LEVEL_W-1:0];
                    default: ;
                endcase
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            pwm_pkg::REG_CAP:  prdata = {12'd0, r_cap_mb};
            pwm_pkg::REG_WARN: prdata = {12'd0, r_warn_mb};
            pwm_pkg::REG_CRIT: prdata = {12'd0, r_crit_mb};
            default:           prdata = '0;
        endcase
    end

    // Stage A: cap_mb / 5 by reciprocal multiply
    assign q5_prod = r_cap_mb * pwm_pkg::RECIP5;

    // Stage B: default levels and clamp against the cap
    assign rem_full  = r_cap_mb - ({r_q5, 2'b00} + {2'b00, r_q5});
    assign rem5      = rem_full[2:0];
    assign div10     = {r_q5, 19'd0} + {18'd0, pwm_pkg::rem5_frac(rem5)};
    assign crit_dflt = {div10, 3'd0} + {3'd0, div10};
    assign cap_x3    = {2'b00, r_cap_mb} + {1'b0, r_cap_mb, 1'b0};
    assign warn_dflt = {cap_x3[19:0], 18'd0} | {cap_x3[21:20], 38'd0};
    assign cap_bytes = {r_cap_mb, 20'd0};

    always_comb begin
        warn_raw = (r_warn_mb != '0) ? {r_warn_mb, 20'd0} : warn_dflt;
        crit_raw = (r_crit_mb != '0) ? {r_crit_mb, 20'd0} : crit_dflt;
        n_warn_thr = (warn_raw >= cap_bytes) ? cap_bytes - (cap_bytes >> 4) : warn_raw;
        n_crit_thr = (crit_raw >= cap_bytes) ? cap_bytes - (cap_bytes >> 5) : crit_raw;
    end

    // Threshold pipeline registers; stage C forms the re-arm levels
    always_ff @(posedge i_clk) begin
        r_q5         <= q5_prod[pwm_pkg::RECIP5_SHIFT +: pwm_pkg::Q5_W];
        r_warn_thr   <= n_warn_thr;
        r_crit_thr   <= n_crit_thr;
        r_warn_rearm <= r_warn_thr - (r_warn_thr >> 3);
        r_crit_rearm <= r_crit_thr - (r_crit_thr >> 3);
    end

    assign o_settled        = (r_settle == 2'd0);
    assign o_thr.enable     = (r_cap_mb != '0);
    assign o_thr.warn_thr   = r_warn_thr;
    assign o_thr.warn_rearm = r_warn_rearm;
    assign o_thr.crit_thr   = r_crit_thr;
    assign o_thr.crit_rearm = r_crit_rearm;

endmodule

[design/pwm_core.sv]
// Per-item datapath: input register, latch and peak update, result register.
module pwm_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_settled,
    input  pwm_pkg::t_thr                i_thr,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [pwm_pkg::TOTAL_W-1:0]  i_total_bytes,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_warn_event,
    output logic                         o_critical_event,
    output logic                         o_warn_active,
    output logic                         o_critical_active,
    output logic [pwm_pkg::TOTAL_W-1:0]  o_peak_bytes
);

    logic                        r_s1_valid, r_out_valid;
    logic [pwm_pkg::TOTAL_W-1:0] r_total;
    logic [pwm_pkg::TOTAL_W-1:0] r_peak, n_peak;
    logic                        r_warn, r_crit, n_warn, n_crit;
    logic                        n_wev, n_cev;
    logic                        r_wev, r_cev;
    logic [pwm_pkg::TOTAL_W-1:0] r_peak_out;
    logic                        r_warn_out, r_crit_out;
    logic                        s1_move, in_take;
    logic [pwm_pkg::TOTAL_W-1:0] wthr, wrearm, cthr, crearm;

    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = i_settled && (!r_s1_valid || s1_move);
    assign in_take    = i_in_valid && o_in_ready;

    assign wthr   = {4'd0, i_thr.warn_thr};
    assign wrearm = {4'd0, i_thr.warn_rearm};
    assign cthr   = {4'd0, i_thr.crit_thr};
    assign crearm = {4'd0, i_thr.crit_rearm};

    // Set on reaching the threshold, re-arm below the hysteresis level
    always_comb begin
        n_peak = r_peak;
        n_warn = r_warn;
        n_crit = r_crit;
        n_wev  = 1'b0;
        n_cev  = 1'b0;
        if (i_thr.enable) begin
            if (r_total > r_peak) begin
                n_peak = r_total;
            end
            if (r_total >= wthr) begin
                n_warn = 1'b1;
                n_wev  = !r_warn;
            end else if (r_total < wrearm) begin
                n_warn = 1'b0;
            end
            if (r_total >= cthr) begin
                n_crit = 1'b1;
                n_cev  = !r_crit;
            end else if (r_total < crearm) begin
                n_crit = 1'b0;
            end
        end
    end

    // Control and monitor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_peak      <= '0;
            r_warn      <= 1'b0;
            r_crit      <= 1'b0;
        end else begin
            if (in_take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
                r_peak      <= n_peak;
                r_warn      <= n_warn;
                r_crit      <= n_crit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: capture the item, hold the result until taken
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_total <= i_total_bytes;
        end
        if (s1_move) begin
            r_wev      <= n_wev;
            r_cev      <= n_cev;
            r_warn_out <= n_warn;
            r_crit_out <= n_crit;
            r_peak_out <= n_peak;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_warn_event      = r_wev;
    assign o_critical_event  = r_cev;
    assign o_warn_active     = r_warn_out;
    assign o_critical_active = r_crit_out;
    assign o_peak_bytes      = r_peak_out;

endmodule

[design/pin_watermark_monitor.sv]
// Top level of the pinned-memory watermark monitor.
// Each item carries a pinned-byte total and passes the input register, then the result
// register: the warning and critical flags, their one-shot set events and the peak total.
// A new item is taken every cycle while results are drained; the result register and
// the input register together let an item enter while the previous result still waits.
// After any APB register write the input stays stalled while the threshold pipeline
// (reciprocal divide by 5, default and clamp, re-arm level) settles.
// Writing cap_mb as zero freezes the peak total and the warning and critical flags.
module pin_watermark_monitor (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pwm_pkg::ADDR_W-1:0]   paddr,
    input  logic [pwm_pkg::DATA_W-1:0]   pwdata,
    output logic [pwm_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [pwm_pkg::TOTAL_W-1:0]  i_total_bytes,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_warn_event,
    output logic                         o_critical_event,
    output logic                         o_warn_active,
    output logic                         o_critical_active,
    output logic [pwm_pkg::TOTAL_W-1:0]  o_peak_bytes
);

    pwm_pkg::t_thr thr;
    logic          settled;

    // Register file and thresholds
    pwm_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_settled (settled),
        .o_thr     (thr)
    );

    // Item datapath
    pwm_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_settled         (settled),
        .i_thr             (thr),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_total_bytes     (i_total_bytes),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_warn_event      (o_warn_event),
        .o_critical_event  (o_critical_event),
        .o_warn_active     (o_warn_active),
        .o_critical_active (o_critical_active),
        .o_peak_bytes      (o_peak_bytes)
    );

endmodule
